// ----- hw/rtl/deadlock_detector_assert.svh -----
// ----------------------------------------------------------------------------
// deadlock detector assertion macros
// immediate-implication and next-cycle checks, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef DEADLOCK_DETECTOR_ASSERT_SVH
`define DEADLOCK_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define DD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deadlock detector check failed");

// antecedent implies consequent in the next cycle
`define DD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deadlock detector check failed");

`else

`define DD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/dd_pkg.sv -----
// ----------------------------------------------------------------------------
// dd_pkg
// shared codes, field widths and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dd_pkg;

    localparam int ACTION_W    = 2;
    localparam int IDX_W       = 4;
    localparam int AMOUNT_W    = 8;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_DATA_W-1:0] CFG_COUNT_RESET = 5'd16;

    localparam logic [ACTION_W-1:0] ACT_LOAD_ENTRY = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_AVAIL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESSES = 2'd1;

    typedef struct packed {
        logic load_entry;
        logic load_avail;
        logic clr_finished;
        logic wr_work_init;
        logic wr_work_add;
        logic set_finished;
    } t_dp_cmd;

    typedef struct packed {
        logic fits;
        logic finished;
    } t_dp_status;

endpackage

// ----- hw/rtl/dd_datapath.sv -----
// ----------------------------------------------------------------------------
// dd_datapath
// request, allocation, available and work stores, finished flags, compare/add
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deadlock_detector_assert.svh"

module dd_datapath #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 16,
    localparam int P_W = $clog2(MAX_PROCESSES),
    localparam int R_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dd_pkg::t_dp_cmd               i_cmd,
    input  logic [P_W-1:0]                i_p_idx,
    input  logic [R_W-1:0]                i_r_idx,
    input  logic [dd_pkg::IDX_W-1:0]      i_process_index,
    input  logic [dd_pkg::IDX_W-1:0]      i_resource_index,
    input  logic [dd_pkg::AMOUNT_W-1:0]   i_request_amount,
    input  logic [dd_pkg::AMOUNT_W-1:0]   i_allocated_amount,
    input  logic [dd_pkg::AMOUNT_W-1:0]   i_available_amount,
    output dd_pkg::t_dp_status            o_status
);
    import dd_pkg::*;

    localparam int DEPTH  = MAX_PROCESSES * MAX_RESOURCES;
    localparam int ADDR_W = $clog2(DEPTH);
    // available plus every allocation never wraps
    localparam int WORK_W = $clog2(255 * (MAX_PROCESSES + 1) + 1);

    logic [AMOUNT_W-1:0] r_req_mem   [DEPTH];
    logic [AMOUNT_W-1:0] r_alloc_mem [DEPTH];
    logic [AMOUNT_W-1:0] r_avail_mem [MAX_RESOURCES];
    logic [WORK_W-1:0]   r_work_mem  [MAX_RESOURCES];

    logic [AMOUNT_W-1:0] r_req_rd;
    logic [AMOUNT_W-1:0] r_alloc_rd;
    logic [AMOUNT_W-1:0] r_avail_rd;
    logic [WORK_W-1:0]   r_work_rd;

    logic [MAX_PROCESSES-1:0] r_finished;
    logic [MAX_PROCESSES-1:0] n_finished;

    logic              w_entry_ok;
    logic              w_avail_ok;
    logic [ADDR_W-1:0] w_load_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [R_W-1:0]    w_avail_addr;
    logic [WORK_W-1:0] w_work_wdata;

    // loads outside the store size set by the parameters are dropped
    assign w_entry_ok   = (32'(i_process_index) < MAX_PROCESSES) &&
                          (32'(i_resource_index) < MAX_RESOURCES);
    assign w_avail_ok   = 32'(i_resource_index) < MAX_RESOURCES;
    assign w_load_addr  = ADDR_W'(32'(i_process_index) * MAX_RESOURCES +
                                  32'(i_resource_index));
    assign w_avail_addr = R_W'(i_resource_index);
    assign w_rd_addr    = ADDR_W'(32'(i_p_idx) * MAX_RESOURCES + 32'(i_r_idx));

    assign w_work_wdata = i_cmd.wr_work_init ? WORK_W'(r_avail_rd)
                                             : WORK_W'(r_work_rd + WORK_W'(r_alloc_rd));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_entry && w_entry_ok) begin
            r_req_mem[w_load_addr]   <= i_request_amount;
            r_alloc_mem[w_load_addr] <= i_allocated_amount;
        end
        if (i_cmd.load_avail && w_avail_ok) begin
            r_avail_mem[w_avail_addr] <= i_available_amount;
        end
        r_req_rd   <= r_req_mem[w_rd_addr];
        r_alloc_rd <= r_alloc_mem[w_rd_addr];
        r_avail_rd <= r_avail_mem[i_r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_work_init || i_cmd.wr_work_add) begin
            r_work_mem[i_r_idx] <= w_work_wdata;
        end
        r_work_rd <= r_work_mem[i_r_idx];
    end

    always_comb begin
        n_finished = r_finished;
        if (i_cmd.clr_finished) begin
            n_finished = '0;
        end else if (i_cmd.set_finished) begin
            n_finished[i_p_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finished <= '0;
        end else begin
            r_finished <= n_finished;
        end
    end

    assign o_status.fits     = WORK_W'(r_req_rd) <= r_work_rd;
    assign o_status.finished = r_finished[i_p_idx];

    `DD_ASSERT_NXT(a_finish_sticks, i_clk, i_rst_n, i_cmd.set_finished && !i_cmd.clr_finished, r_finished[$past(i_p_idx)])
    `DD_ASSERT_IMP(a_one_work_write, i_clk, i_rst_n, i_cmd.wr_work_init, !i_cmd.wr_work_add)

endmodule

// ----- hw/rtl/dd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dd_ctrl
// sequencer for loads and detection passes, config registers, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deadlock_detector_assert.svh"

module dd_ctrl #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 16,
    localparam int P_W = $clog2(MAX_PROCESSES),
    localparam int R_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dd_pkg::ACTION_W-1:0]     i_action,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_deadlocked,
    output dd_pkg::t_dp_cmd                 o_cmd,
    output logic [P_W-1:0]                  o_p_idx,
    output logic [R_W-1:0]                  o_r_idx,
    input  dd_pkg::t_dp_status              i_status
);
    import dd_pkg::*;

    localparam int PC_W = $clog2(MAX_PROCESSES + 1);
    localparam int RC_W = $clog2(MAX_RESOURCES + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT_RD = 4'd1;
    localparam logic [3:0] S_INIT_WR = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_FIT_RD  = 4'd4;
    localparam logic [3:0] S_FIT_CMP = 4'd5;
    localparam logic [3:0] S_ADD_RD  = 4'd6;
    localparam logic [3:0] S_ADD_WR  = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]            r_st, n_st;
    logic [CFG_DATA_W-1:0] r_res_cfg, n_res_cfg;
    logic [CFG_DATA_W-1:0] r_proc_cfg, n_proc_cfg;
    logic [RC_W-1:0]       r_nres, n_nres;
    logic [PC_W-1:0]       r_nproc, n_nproc;
    logic [RC_W-1:0]       r_r, n_r;
    logic [PC_W-1:0]       r_p, n_p;
    logic                  r_seen, n_seen;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_dl, n_out_dl;

    logic            w_accept;
    logic [RC_W-1:0] w_nres_clamp;
    logic [PC_W-1:0] w_nproc_clamp;

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_nres_clamp  = (32'(r_res_cfg) > MAX_RESOURCES) ? RC_W'(MAX_RESOURCES)
                                                             : RC_W'(r_res_cfg);
    assign w_nproc_clamp = (32'(r_proc_cfg) > MAX_PROCESSES) ? PC_W'(MAX_PROCESSES)
                                                              : PC_W'(r_proc_cfg);

    always_comb begin
        n_st        = r_st;
        n_res_cfg   = r_res_cfg;
        n_proc_cfg  = r_proc_cfg;
        n_nres      = r_nres;
        n_nproc     = r_nproc;
        n_r         = r_r;
        n_p         = r_p;
        n_seen      = r_seen;
        n_out_valid = r_out_valid;
        n_out_dl    = r_out_dl;
        o_cmd       = '0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RESOURCES: n_res_cfg  = i_cfg_data;
                CFG_PROCESSES: n_proc_cfg = i_cfg_data;
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_st)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        ACT_LOAD_ENTRY: o_cmd.load_entry = 1'b1;
                        ACT_LOAD_AVAIL: o_cmd.load_avail = 1'b1;
                        ACT_CHECK: begin
                            n_nres             = w_nres_clamp;
                            n_nproc            = w_nproc_clamp;
                            n_r                = '0;
                            n_p                = '0;
                            n_seen             = 1'b0;
                            o_cmd.clr_finished = 1'b1;
                            n_st               = S_INIT_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT_RD: begin
                if (r_r >= r_nres) begin
                    n_r  = '0;
                    n_st = S_SCAN;
                end else begin
                    n_st = S_INIT_WR;
                end
            end
            S_INIT_WR: begin
                o_cmd.wr_work_init = 1'b1;
                n_r                = RC_W'(r_r + 1'b1);
                n_st               = S_INIT_RD;
            end
            S_SCAN: begin
                if (r_p >= r_nproc) begin
                    n_st = S_DONE;
                end else if (i_status.finished) begin
                    n_p = PC_W'(r_p + 1'b1);
                end else begin
                    n_r  = '0;
                    n_st = S_FIT_RD;
                end
            end
            S_FIT_RD: begin
                if (r_r >= r_nres) begin
                    // every request fits: release this process
                    o_cmd.set_finished = 1'b1;
                    n_seen             = 1'b0;
                    n_r                = '0;
                    n_st               = S_ADD_RD;
                end else begin
                    n_st = S_FIT_CMP;
                end
            end
            S_FIT_CMP: begin
                if (!i_status.fits) begin
                    n_seen = 1'b1;
                    n_p    = PC_W'(r_p + 1'b1);
                    n_st   = S_SCAN;
                end else begin
                    n_r  = RC_W'(r_r + 1'b1);
                    n_st = S_FIT_RD;
                end
            end
            S_ADD_RD: begin
                if (r_r >= r_nres) begin
                    // rescan from the first process
                    n_p  = '0;
                    n_st = S_SCAN;
                end else begin
                    n_st = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                o_cmd.wr_work_add = 1'b1;
                n_r               = RC_W'(r_r + 1'b1);
                n_st              = S_ADD_RD;
            end
            S_DONE: begin
                // a pass with no release: any failed process stays stuck
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_dl    = r_seen;
                    n_st        = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_res_cfg   <= CFG_COUNT_RESET;
            r_proc_cfg  <= CFG_COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_res_cfg   <= n_res_cfg;
            r_proc_cfg  <= n_proc_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nres   <= n_nres;
        r_nproc  <= n_nproc;
        r_r      <= n_r;
        r_p      <= n_p;
        r_seen   <= n_seen;
        r_out_dl <= n_out_dl;
    end

    assign o_out_valid  = r_out_valid;
    assign o_deadlocked = r_out_dl;
    assign o_p_idx      = r_p[P_W-1:0];
    assign o_r_idx      = r_r[R_W-1:0];

    `DD_ASSERT_IMP(a_res_in_range, i_clk, i_rst_n, (r_st == S_FIT_CMP) || (r_st == S_ADD_WR) || (r_st == S_INIT_WR), r_r < r_nres)
    `DD_ASSERT_IMP(a_proc_bounded, i_clk, i_rst_n, r_st != S_IDLE, r_p <= r_nproc)
    `DD_ASSERT_IMP(a_no_procs_clear, i_clk, i_rst_n, (r_st == S_DONE) && (r_nproc == '0), !r_seen)

endmodule

// ----- hw/rtl/deadlock_detector.sv -----
// ----------------------------------------------------------------------------
// deadlock_detector
// load item: one accepted per cycle while idle
// check item: seeds work from the available counts, then scans the processes,
//   compares each request with work, adds a released process's allocation and
//   rescans from the first process, then closes; each store has one read port
// reset: control state idle, result empty, both counts 16; stores undefined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadlock_detector #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // process_index, resource_index, request_amount, allocated_amount, available_amount
    input  logic [dd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic [dd_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // deadlocked, zero fill
    output logic [dd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dd_pkg::*;

    localparam int P_W = $clog2(MAX_PROCESSES);
    localparam int R_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [P_W-1:0] w_p_idx;
    logic [R_W-1:0] w_r_idx;
    logic           w_deadlocked;

    dd_ctrl #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_deadlocked (w_deadlocked),
        .o_cmd        (w_cmd),
        .o_p_idx      (w_p_idx),
        .o_r_idx      (w_r_idx),
        .i_status     (w_status)
    );

    dd_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_p_idx            (w_p_idx),
        .i_r_idx            (w_r_idx),
        .i_process_index    (s_axis_tdata[3:0]),
        .i_resource_index   (s_axis_tdata[7:4]),
        .i_request_amount   (s_axis_tdata[15:8]),
        .i_allocated_amount (s_axis_tdata[23:16]),
        .i_available_amount (s_axis_tdata[31:24]),
        .o_status           (w_status)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, w_deadlocked};

endmodule

// ----- sim/tb_deadlock_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadlock_detector
// drives load and check requests into the detector with random gaps on both
// stream sides, predicts verdicts from a local copy of the request, allocation
// and available stores or takes them from a directed row, and compares results in arrival order
// ----------------------------------------------------------------------------

module tb_deadlock_detector;
    import dd_pkg::*;

    localparam int PROCS = 16;
    localparam int RSRCS = 16;
    localparam int TARGET_ITEMS = 650;
    localparam int LONG_HOLD = 600;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [IDX_W-1:0]    proc;
        logic [IDX_W-1:0]    res;
        logic [AMOUNT_W-1:0] req;
        logic [AMOUNT_W-1:0] held;
        logic [AMOUNT_W-1:0] free;
    } t_item;

    typedef struct packed {
        t_item it;
        logic  typed;
        logic  verdict;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ACTION_W-1:0]    s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    deadlock_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // local copy of the block state
    logic [AMOUNT_W-1:0] req_mem  [PROCS][RSRCS];
    logic [AMOUNT_W-1:0] held_mem [PROCS][RSRCS];
    logic [AMOUNT_W-1:0] free_mem [RSRCS];
    bit                  entry_seen [PROCS][RSRCS];
    bit                  free_seen  [RSRCS];
    logic [CFG_DATA_W-1:0] res_in_use  = CFG_COUNT_RESET;
    logic [CFG_DATA_W-1:0] proc_in_use = CFG_COUNT_RESET;

    logic   pending_verdicts [$];
    int     errors = 0;
    int     total_items = 0;
    bit     no_idle = 1'b0;
    bit     hold_req = 1'b0;
    longint budget = 5000 + LONG_HOLD;
    longint cycles = 0;

    t_dir_row dir_rows [16];

    function automatic int active_res();
        return (res_in_use > RSRCS) ? RSRCS : int'(res_in_use);
    endfunction

    function automatic int active_procs();
        return (proc_in_use > PROCS) ? PROCS : int'(proc_in_use);
    endfunction

    function automatic logic predict_deadlock();
        logic [12:0] work [RSRCS];
        bit          done [PROCS];
        int          nres;
        int          nproc;
        bit          progress;
        bit          fits;
        logic        stuck;
        nres = active_res();
        nproc = active_procs();
        for (int r = 0; r < RSRCS; r++) work[r] = '0;
        for (int p = 0; p < PROCS; p++) done[p] = 1'b0;
        for (int r = 0; r < nres; r++) work[r] = 13'(free_mem[r]);
        progress = 1'b1;
        while (progress) begin
            progress = 1'b0;
            for (int p = 0; p < nproc && !progress; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < nres; r++) begin
                        if (13'(req_mem[p][r]) > work[r]) fits = 1'b0;
                    end
                    if (fits) begin
                        done[p] = 1'b1;
                        for (int r = 0; r < nres; r++) work[r] = work[r] + 13'(held_mem[p][r]);
                        progress = 1'b1;
                    end
                end
            end
        end
        stuck = 1'b0;
        for (int p = 0; p < nproc; p++) if (!done[p]) stuck = 1'b1;
        return stuck;
    endfunction

    // every entry a check would read has been loaded
    function automatic bit stores_ready();
        bit ok;
        ok = 1'b1;
        for (int r = 0; r < active_res(); r++) begin
            if (!free_seen[r]) ok = 1'b0;
            for (int p = 0; p < active_procs(); p++) if (!entry_seen[p][r]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [AMOUNT_W-1:0] pick_amount();
        int k;
        k = $urandom_range(0, 99);
        if (k < 72) return AMOUNT_W'($urandom_range(0, 6));
        if (k < 80) return '1;
        if (k < 85) return '0;
        return AMOUNT_W'($urandom_range(0, 255));
    endfunction

    function automatic t_dir_row dir_row(logic [ACTION_W-1:0] action, int p, int r,
                                         int req, int held, int free, bit typed, bit v);
        t_dir_row d;
        d.it = '{action, IDX_W'(p), IDX_W'(r), AMOUNT_W'(req), AMOUNT_W'(held),
                 AMOUNT_W'(free)};
        d.typed = typed;
        d.verdict = v;
        return d;
    endfunction

    function automatic t_item any_item(logic [ACTION_W-1:0] action);
        t_item it;
        it.action = action;
        it.proc = IDX_W'($urandom);
        it.res = IDX_W'($urandom);
        it.req = pick_amount();
        it.held = pick_amount();
        it.free = pick_amount();
        return it;
    endfunction

    // next load that covers an entry the current sizes would read unwritten
    function automatic t_item fill_item();
        t_item it;
        bit    found;
        it = any_item(ACT_LOAD_AVAIL);
        found = 1'b0;
        for (int r = 0; r < active_res() && !found; r++) begin
            if (!free_seen[r]) begin
                it.res = IDX_W'(r);
                found = 1'b1;
            end
        end
        for (int p = 0; p < active_procs() && !found; p++) begin
            for (int r = 0; r < active_res() && !found; r++) begin
                if (!entry_seen[p][r]) begin
                    it.action = ACT_LOAD_ENTRY;
                    it.proc = IDX_W'(p);
                    it.res = IDX_W'(r);
                    found = 1'b1;
                end
            end
        end
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    roll;
        int    plim;
        int    rlim;
        plim = (active_procs() < 1) ? 1 : active_procs();
        rlim = (active_res() < 1) ? 1 : active_res();
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            it = any_item(ACT_LOAD_ENTRY);
            it.proc = IDX_W'($urandom_range(0, plim - 1));
            it.res = IDX_W'($urandom_range(0, rlim - 1));
        end else if (roll < 60) begin
            it = any_item(ACT_LOAD_AVAIL);
            it.res = IDX_W'($urandom_range(0, rlim - 1));
        end else if (roll < 85) begin
            it = any_item(ACT_CHECK);
        end else if (roll < 90) begin
            it = any_item(ACT_UNUSED);
        end else begin
            it = any_item(($urandom_range(0, 1) != 0) ? ACT_LOAD_ENTRY : ACT_LOAD_AVAIL);
        end
        return it;
    endfunction

    task automatic absorb_item(input t_item it, input bit typed, input logic typed_v);
        logic v;
        case (it.action)
            ACT_LOAD_ENTRY: begin
                req_mem[it.proc][it.res] = it.req;
                held_mem[it.proc][it.res] = it.held;
                entry_seen[it.proc][it.res] = 1'b1;
            end
            ACT_LOAD_AVAIL: begin
                free_mem[it.res] = it.free;
                free_seen[it.res] = 1'b1;
            end
            ACT_CHECK: begin
                v = predict_deadlock();
                pending_verdicts.push_back(typed ? typed_v : v);
                budget += longint'(active_procs() + 2) * (active_procs() + 1)
                          * (2 * active_res() + 2) + 2 * active_res() + 64;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input t_item it, input bit typed, input logic typed_v);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 37) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                budget += 4;
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.free, it.held, it.req, it.res, it.proc};
        s_axis_tuser <= it.action;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        absorb_item(it, typed, typed_v);
        budget += 40;
        total_items++;
        if (total_items == 200) hold_req = 1'b1;
        no_idle = (total_items >= 400 && total_items < 480);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_RESOURCES) res_in_use = val;
        else if (idx == CFG_PROCESSES) proc_in_use = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        budget += 40;
    endtask

    // stop the stream and let the block go quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // result checker
    logic want_v;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0b",
                         $time, m_axis_tdata[0]);
                errors++;
            end else begin
                want_v = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want_v) begin
                    $display("%0t: deadlocked mismatch, expected %0b, actual %0b",
                             $time, want_v, m_axis_tdata[0]);
                    errors++;
                end
            end
        end
    end

    // result side backpressure, with one long hold-off while requests keep coming
    int  hold_left = 0;
    bit  held_once = 1'b0;
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !held_once) begin
            held_once <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 4 * budget + 20000) begin
            $display("tb_deadlock_detector: FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        int phase;
        int res_val;
        int proc_val;
        int fixed_res  [10];
        int fixed_proc [10];

        fixed_res  = '{16, 0, 16, 0, 31, 17, 2, 5, 1, 16};
        fixed_proc = '{16, 16, 0, 0, 31, 3, 2, 20, 16, 1};

        for (int p = 0; p < PROCS; p++) begin
            for (int r = 0; r < RSRCS; r++) begin
                req_mem[p][r] = '0;
                held_mem[p][r] = '0;
                entry_seen[p][r] = 1'b0;
            end
        end
        for (int r = 0; r < RSRCS; r++) begin
            free_mem[r] = '0;
            free_seen[r] = 1'b0;
        end

        // one process, one resource: verdicts readable by eye
        dir_rows[0]  = dir_row(ACT_LOAD_ENTRY, 0, 0, 0, 0, 0, 0, 0);
        dir_rows[1]  = dir_row(ACT_LOAD_AVAIL, 0, 0, 0, 0, 0, 0, 0);
        dir_rows[2]  = dir_row(ACT_CHECK, 0, 0, 0, 0, 0, 1, 0);
        dir_rows[3]  = dir_row(ACT_LOAD_ENTRY, 0, 0, 255, 255, 0, 0, 0);
        dir_rows[4]  = dir_row(ACT_CHECK, 15, 15, 255, 255, 255, 1, 1);
        dir_rows[5]  = dir_row(ACT_LOAD_AVAIL, 9, 0, 170, 85, 255, 0, 0);
        dir_rows[6]  = dir_row(ACT_CHECK, 0, 0, 0, 0, 0, 1, 0);
        // unused action must leave the available count alone
        dir_rows[7]  = dir_row(ACT_UNUSED, 0, 0, 255, 255, 0, 0, 0);
        dir_rows[8]  = dir_row(ACT_CHECK, 5, 10, 85, 170, 0, 1, 0);
        dir_rows[9]  = dir_row(ACT_LOAD_ENTRY, 15, 15, 255, 255, 255, 0, 0);
        dir_rows[10] = dir_row(ACT_LOAD_AVAIL, 0, 15, 0, 0, 255, 0, 0);
        dir_rows[11] = dir_row(ACT_LOAD_ENTRY, 0, 0, 7, 3, 0, 0, 0);
        dir_rows[12] = dir_row(ACT_LOAD_AVAIL, 0, 0, 0, 0, 6, 0, 0);
        dir_rows[13] = dir_row(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0);
        dir_rows[14] = dir_row(ACT_LOAD_AVAIL, 0, 0, 0, 0, 7, 0, 0);
        dir_rows[15] = dir_row(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_cfg(CFG_RESOURCES, CFG_DATA_W'(1));
        write_cfg(CFG_PROCESSES, CFG_DATA_W'(1));
        foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].verdict);

        phase = 0;
        while (total_items < TARGET_ITEMS) begin
            if (phase < 10) begin
                res_val = fixed_res[phase];
                proc_val = fixed_proc[phase];
            end else begin
                res_val = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                                       : $urandom_range(0, 31);
                proc_val = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                                        : $urandom_range(0, 31);
            end
            drain();
            write_cfg(CFG_RESOURCES, CFG_DATA_W'(res_val));
            write_cfg(CFG_PROCESSES, CFG_DATA_W'(proc_val));
            // load whatever the new sizes would read, with some noise mixed in
            while (!stores_ready()) begin
                if ($urandom_range(0, 99) < 15) send_item(any_item(ACT_UNUSED), 1'b0, 1'b0);
                else send_item(fill_item(), 1'b0, 1'b0);
            end
            n = $urandom_range(25, 45);
            repeat (n) send_item(random_item(), 1'b0, 1'b0);
            phase++;
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_deadlock_detector: PASS");
        end else begin
            $display("tb_deadlock_detector: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dd_pkg.sv
hw/rtl/dd_datapath.sv
hw/rtl/dd_ctrl.sv
hw/rtl/deadlock_detector.sv
sim/tb_deadlock_detector.sv
